@@ rtl/core/les_pkg.sv @@
// ----------------------------------------------------------------------------
// les_pkg
// Shared widths, register codes, controller/datapath bundles and the
// saturating fixed-point helpers of the Lorenz Euler step block.
// ----------------------------------------------------------------------------
package les_pkg;

	// word format of the point and of all intermediate values
	localparam int WORD_BITS = 40;
	localparam int FRAC_BITS = 28;
	localparam int HALF_BITS = WORD_BITS / 2;
	localparam int HI_BITS   = WORD_BITS - HALF_BITS;
	localparam int PROD_BITS = 2 * WORD_BITS;

	// port field widths
	localparam int IO_BITS    = 40;
	localparam int CNT_BITS   = 20;
	localparam int COEF_BITS  = 39;
	localparam int SMALL_BITS = 29;
	localparam int EXT_BITS   = IO_BITS + WORD_BITS;

	localparam int IN_DATA_BITS  = ((3 * IO_BITS + 7) / 8) * 8;
	localparam int OUT_RAW_BITS  = 3 * IO_BITS + CNT_BITS + 3;
	localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 39;

	localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_SIGMA     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RHO       = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BETA      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEP_H    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_STEPS = 3'd5;

	// register reset values
	localparam logic [COEF_BITS-1:0]  SIGMA_RST = 39'd2684354560;
	localparam logic [COEF_BITS-1:0]  RHO_RST   = 39'd5368709120;
	localparam logic [COEF_BITS-1:0]  BETA_RST  = 39'd715827883;
	localparam logic [SMALL_BITS-1:0] STEP_RST  = 29'd268435;
	localparam logic [SMALL_BITS-1:0] TOL_RST   = 29'd2684;
	localparam logic [CNT_BITS-1:0]   MAX_RST   = 20'd100000;

	// item kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	// multiply operations, issued in this order
	localparam logic [2:0] OP_DX = 3'd0;
	localparam logic [2:0] OP_M1 = 3'd1;
	localparam logic [2:0] OP_M2 = 3'd2;
	localparam logic [2:0] OP_M3 = 3'd3;
	localparam logic [2:0] OP_IX = 3'd4;
	localparam logic [2:0] OP_IY = 3'd5;
	localparam logic [2:0] OP_IZ = 3'd6;

	typedef struct packed {
		logic       load;
		logic       clear;
		logic       diff;
		logic       mul_start;
		logic [2:0] op;
		logic       update;
		logic       out_load;
	} les_cmd_t;

	typedef struct packed {
		logic can_step;
		logic mul_done;
	} les_stat_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] value;
		logic                        sat;
	} sres_t;

	// a + b or a - b, clipped to the word range
	function automatic sres_t sat_sum(input logic signed [WORD_BITS-1:0] a,
			input logic signed [WORD_BITS-1:0] b, input logic sub);
		logic signed [WORD_BITS:0] ae;
		logic signed [WORD_BITS:0] be;
		logic signed [WORD_BITS:0] s;
		sres_t r;
		ae = {a[WORD_BITS-1], a};
		be = {b[WORD_BITS-1], b};
		s = sub ? (ae - be) : (ae + be);
		r.sat = s[WORD_BITS] != s[WORD_BITS-1];
		if (r.sat) begin
			r.value = s[WORD_BITS] ? WMIN : WMAX;
		end else begin
			r.value = s[WORD_BITS-1:0];
		end
		return r;
	endfunction

	// coefficient register to word, clipped silently
	function automatic logic signed [WORD_BITS-1:0] to_coef(input logic [COEF_BITS-1:0] v);
		logic [COEF_BITS+WORD_BITS-1:0] ve;
		logic [COEF_BITS+WORD_BITS-1:0] wm;
		ve = {{WORD_BITS{1'b0}}, v};
		wm = {{COEF_BITS{1'b0}}, WMAX};
		if (ve > wm) begin
			return WMAX;
		end
		return signed'(ve[WORD_BITS-1:0]);
	endfunction

	// start value to word, clipped with flag
	function automatic sres_t load_word(input logic signed [IO_BITS-1:0] v);
		logic signed [EXT_BITS-1:0] ve;
		logic signed [EXT_BITS-1:0] mx;
		logic signed [EXT_BITS-1:0] mn;
		sres_t r;
		ve = EXT_BITS'(v);
		mx = EXT_BITS'(WMAX);
		mn = EXT_BITS'(WMIN);
		r.sat = 1'b0;
		r.value = WORD_BITS'(ve);
		if (ve > mx) begin
			r.sat = 1'b1;
			r.value = WMAX;
		end else if (ve < mn) begin
			r.sat = 1'b1;
			r.value = WMIN;
		end
		return r;
	endfunction

	// strict |v| < tol
	function automatic logic is_small(input logic signed [WORD_BITS-1:0] v,
			input logic [SMALL_BITS-1:0] tol);
		logic signed [WORD_BITS:0] ve;
		logic signed [WORD_BITS:0] te;
		ve = {v[WORD_BITS-1], v};
		te = signed'({{(WORD_BITS+1-SMALL_BITS){1'b0}}, tol});
		return (ve < te) && (ve > -te);
	endfunction

endpackage

@@ rtl/core/les_mul.sv @@
// ----------------------------------------------------------------------------
// les_mul
// Iterative fixed-point multiplier: sign-magnitude product built from two
// half-width partial products, rounded half away from zero and saturated.
// ----------------------------------------------------------------------------
module les_mul import les_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [WORD_BITS-1:0] a,
	input  logic signed [WORD_BITS-1:0] b,
	output logic signed [WORD_BITS-1:0] res,
	output logic                        sat,
	output logic                        done
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_LO   = 3'd1;
	localparam logic [2:0] PH_HI   = 3'd2;
	localparam logic [2:0] PH_SUM  = 3'd3;
	localparam logic [2:0] PH_RND  = 3'd4;
	localparam logic [2:0] PH_DONE = 3'd5;

	localparam logic [PROD_BITS-1:0] RND_ONE = PROD_BITS'(1) << (FRAC_BITS - 1);
	localparam logic [PROD_BITS-1:0] LIM_POS = PROD_BITS'(WMAX) & ((PROD_BITS'(1) << WORD_BITS) - 1'b1);
	localparam logic [PROD_BITS-1:0] LIM_NEG = PROD_BITS'(1) << (WORD_BITS - 1);

	logic [2:0]                   phase_q;
	logic [WORD_BITS-1:0]         ua_q;
	logic [WORD_BITS-1:0]         ub_q;
	logic                         neg_q;
	logic [WORD_BITS+HI_BITS-1:0] pp_lo_q;
	logic [WORD_BITS+HI_BITS-1:0] pp_hi_q;
	logic [PROD_BITS-1:0]         sum_q;
	logic signed [WORD_BITS-1:0]  res_q;
	logic                         sat_q;

	logic [WORD_BITS-1:0]         ua_c;
	logic [WORD_BITS-1:0]         ub_c;
	logic [HI_BITS-1:0]           mb;
	logic [WORD_BITS+HI_BITS-1:0] pp;
	logic [PROD_BITS-1:0]         mag;
	logic [PROD_BITS-1:0]         lim;
	logic [PROD_BITS-1:0]         mag_c;

	// magnitudes; the most negative word maps to 2^(n-1), which still fits
	assign ua_c = a[WORD_BITS-1] ? (~a + 1'b1) : a;
	assign ub_c = b[WORD_BITS-1] ? (~b + 1'b1) : b;

	// one shared multiplier, low half of b first
	assign mb = (phase_q == PH_LO) ? HI_BITS'(ub_q[HALF_BITS-1:0])
		: ub_q[WORD_BITS-1:HALF_BITS];
	assign pp = (WORD_BITS+HI_BITS)'(ua_q) * (WORD_BITS+HI_BITS)'(mb);

	assign mag   = sum_q >> FRAC_BITS;
	assign lim   = neg_q ? LIM_NEG : LIM_POS;
	assign mag_c = (mag > lim) ? lim : mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			unique case (phase_q)
				PH_IDLE: if (start) phase_q <= PH_LO;
				PH_LO:   phase_q <= PH_HI;
				PH_HI:   phase_q <= PH_SUM;
				PH_SUM:  phase_q <= PH_RND;
				PH_RND:  phase_q <= PH_DONE;
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && start) begin
			ua_q  <= ua_c;
			ub_q  <= ub_c;
			neg_q <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
		end
		if (phase_q == PH_LO) begin
			pp_lo_q <= pp;
		end
		if (phase_q == PH_HI) begin
			pp_hi_q <= pp;
		end
		if (phase_q == PH_SUM) begin
			sum_q <= PROD_BITS'(pp_lo_q) + (PROD_BITS'(pp_hi_q) << HALF_BITS) + RND_ONE;
		end
		if (phase_q == PH_RND) begin
			sat_q <= mag > lim;
			res_q <= neg_q ? signed'(-mag_c[WORD_BITS-1:0]) : signed'(mag_c[WORD_BITS-1:0]);
		end
	end

	assign res  = res_q;
	assign sat  = sat_q;
	assign done = phase_q == PH_DONE;

endmodule

@@ rtl/core/les_dp.sv @@
// ----------------------------------------------------------------------------
// les_dp
// Datapath: configuration registers, point and step state, derivative
// temporaries, the shared multiplier and the output register.
// ----------------------------------------------------------------------------
module les_dp import les_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  les_cmd_t                 cmd,
	output les_stat_t                stat,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output logic [OUT_DATA_BITS-1:0] m_tdata
);

	logic [COEF_BITS-1:0]  sigma_q;
	logic [COEF_BITS-1:0]  rho_q;
	logic [COEF_BITS-1:0]  beta_q;
	logic [SMALL_BITS-1:0] step_h_q;
	logic [SMALL_BITS-1:0] tol_q;
	logic [CNT_BITS-1:0]   max_q;

	logic signed [WORD_BITS-1:0] px_q, py_q, pz_q;
	logic [CNT_BITS-1:0]         steps_q;
	logic                        halted_q;
	logic                        sat_q;

	logic signed [WORD_BITS-1:0] d1_q, d2_q, dx_q, dy_q, m2_q, dz_q;
	logic signed [WORD_BITS-1:0] ix_q, iy_q, iz_q;
	logic [2:0]                  op_q;
	logic [OUT_DATA_BITS-1:0]    out_q;

	logic signed [WORD_BITS-1:0] sg, rh, bt, hw;
	logic signed [WORD_BITS-1:0] mul_a, mul_b, mul_res;
	logic                        mul_sat, mul_done;
	sres_t lx, ly, lz, sd1, sd2, dysub, dzsub, ax, ay, az;
	logic                        sat_ev;
	logic                        limit;

	assign sg = to_coef(sigma_q);
	assign rh = to_coef(rho_q);
	assign bt = to_coef(beta_q);
	assign hw = signed'(WORD_BITS'(step_h_q));

	assign lx = load_word(signed'(s_tdata[IO_BITS-1:0]));
	assign ly = load_word(signed'(s_tdata[2*IO_BITS-1:IO_BITS]));
	assign lz = load_word(signed'(s_tdata[3*IO_BITS-1:2*IO_BITS]));

	assign sd1   = sat_sum(py_q, px_q, 1'b1);
	assign sd2   = sat_sum(rh, pz_q, 1'b1);
	assign dysub = sat_sum(mul_res, py_q, 1'b1);
	assign dzsub = sat_sum(m2_q, mul_res, 1'b1);
	assign ax    = sat_sum(px_q, ix_q, 1'b0);
	assign ay    = sat_sum(py_q, iy_q, 1'b0);
	assign az    = sat_sum(pz_q, iz_q, 1'b0);

	always_comb begin
		unique case (cmd.op)
			OP_DX: begin mul_a = sg;   mul_b = d1_q; end
			OP_M1: begin mul_a = px_q; mul_b = d2_q; end
			OP_M2: begin mul_a = px_q; mul_b = py_q; end
			OP_M3: begin mul_a = bt;   mul_b = pz_q; end
			OP_IX: begin mul_a = hw;   mul_b = dx_q; end
			OP_IY: begin mul_a = hw;   mul_b = dy_q; end
			OP_IZ: begin mul_a = hw;   mul_b = dz_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	les_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.res    (mul_res),
		.sat    (mul_sat),
		.done   (mul_done)
	);

	// clip events of this cycle
	always_comb begin
		sat_ev = 1'b0;
		if (cmd.diff) begin
			sat_ev = sd1.sat | sd2.sat;
		end
		if (mul_done) begin
			sat_ev = mul_sat | ((op_q == OP_M1) & dysub.sat) | ((op_q == OP_M3) & dzsub.sat);
		end
		if (cmd.update) begin
			sat_ev = ax.sat | ay.sat | az.sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q  <= SIGMA_RST;
			rho_q    <= RHO_RST;
			beta_q   <= BETA_RST;
			step_h_q <= STEP_RST;
			tol_q    <= TOL_RST;
			max_q    <= MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIGMA:     sigma_q  <= cfg_data[COEF_BITS-1:0];
				REG_RHO:       rho_q    <= cfg_data[COEF_BITS-1:0];
				REG_BETA:      beta_q   <= cfg_data[COEF_BITS-1:0];
				REG_STEP_H:    step_h_q <= cfg_data[SMALL_BITS-1:0];
				REG_TOLERANCE: tol_q    <= cfg_data[SMALL_BITS-1:0];
				REG_MAX_STEPS: max_q    <= cfg_data[CNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q     <= '0;
			py_q     <= '0;
			pz_q     <= '0;
			steps_q  <= '0;
			halted_q <= 1'b0;
			sat_q    <= 1'b0;
		end else if (cmd.load) begin
			px_q     <= lx.value;
			py_q     <= ly.value;
			pz_q     <= lz.value;
			steps_q  <= '0;
			halted_q <= 1'b0;
			sat_q    <= lx.sat | ly.sat | lz.sat;
		end else begin
			if (cmd.clear) begin
				sat_q <= 1'b0;
			end else begin
				sat_q <= sat_q | sat_ev;
			end
			if (cmd.update) begin
				px_q    <= ax.value;
				py_q    <= ay.value;
				pz_q    <= az.value;
				steps_q <= steps_q + 1'b1;
				// sticky until the next load
				if (is_small(ix_q, tol_q) && is_small(iy_q, tol_q) && is_small(iz_q, tol_q)) begin
					halted_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			d1_q <= sd1.value;
			d2_q <= sd2.value;
		end
		if (cmd.mul_start) begin
			op_q <= cmd.op;
		end
		if (mul_done) begin
			unique case (op_q)
				OP_DX: dx_q <= mul_res;
				OP_M1: dy_q <= dysub.value;
				OP_M2: m2_q <= mul_res;
				OP_M3: dz_q <= dzsub.value;
				OP_IX: ix_q <= mul_res;
				OP_IY: iy_q <= mul_res;
				OP_IZ: iz_q <= mul_res;
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			out_q <= OUT_DATA_BITS'({sat_q, limit, halted_q, steps_q,
				IO_BITS'(pz_q), IO_BITS'(py_q), IO_BITS'(px_q)});
		end
	end

	assign limit = steps_q >= max_q;

	assign stat.can_step = !halted_q && (steps_q < max_q);
	assign stat.mul_done = mul_done;
	assign m_tdata       = out_q;

endmodule

@@ rtl/core/les_ctrl.sv @@
// ----------------------------------------------------------------------------
// les_ctrl
// Controller: accepts items, sequences the difference, the seven multiplies
// and the point update, and owns the output valid.
// ----------------------------------------------------------------------------
module les_ctrl import les_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	input  logic      s_tuser,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  les_stat_t stat,
	output les_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_DIFF      = 3'd1;
	localparam logic [2:0] S_MUL_ISSUE = 3'd2;
	localparam logic [2:0] S_MUL_WAIT  = 3'd3;
	localparam logic [2:0] S_UPDATE    = 3'd4;
	localparam logic [2:0] S_FINISH    = 3'd5;

	logic [2:0] state_q, state_d;
	logic [2:0] op_q, op_d;
	logic       m_valid_q;

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		cmd     = '0;
		cmd.op  = op_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == KIND_LOAD) begin
						cmd.load = 1'b1;
						state_d  = S_FINISH;
					end else begin
						cmd.clear = 1'b1;
						// halted or at the limit: the item only clears the saturation flag
						state_d = stat.can_step ? S_DIFF : S_FINISH;
					end
				end
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				op_d     = OP_DX;
				state_d  = S_MUL_ISSUE;
			end
			S_MUL_ISSUE: begin
				cmd.mul_start = 1'b1;
				state_d       = S_MUL_WAIT;
			end
			S_MUL_WAIT: begin
				if (stat.mul_done) begin
					if (op_q == OP_IZ) begin
						state_d = S_UPDATE;
					end else begin
						op_d    = op_q + 1'b1;
						state_d = S_MUL_ISSUE;
					end
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				if (!m_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_DX;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_valid_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.mul_done |-> state_q == S_MUL_WAIT)
		else $error("multiplier finished outside the wait state");

	a_skip_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && s_tvalid && s_tuser == KIND_STEP && !stat.can_step)
		|=> state_q == S_FINISH)
		else $error("refused step did not go straight to the result");

	a_update_after_all: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPDATE |-> op_q == OP_IZ)
		else $error("point update before the last increment");

endmodule

@@ rtl/core/lorenz_euler_step.sv @@
// ----------------------------------------------------------------------------
// lorenz_euler_step
// Forward Euler integrator of the Lorenz system in signed Q12.28 fixed point.
// ----------------------------------------------------------------------------
// One item at a time. A load item goes from acceptance to the finish state, where
// its result is registered once the output register is free; the block then
// returns to idle and can accept the next item. A step item passes through the
// difference state, seven multiplies on the single shared multiplier (each an
// issue, two half-width partial products, a sum, rounding and write-back), the
// point update and the finish state. A refused step (halted or at the step
// limit) is timed like a load.
// A result waits in the output register; the next item is accepted meanwhile,
// but its result is held back until the previous one is taken. Configuration
// is written through cfg_we/cfg_index/cfg_data; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module lorenz_euler_step import les_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,   // x_in, y_in, z_in
	input  logic                     s_tuser,   // kind
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,   // x_out, y_out, z_out, step_count,
	                                            // converged, limit_reached, saturated
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	les_cmd_t  cmd;
	les_stat_t stat;

	les_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	les_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tdata   (m_tdata)
	);

endmodule

@@ sim/lorenz_euler_step_tb.sv @@
// ----------------------------------------------------------------------------
// lorenz_euler_step_tb
// Self-checking bench for the Lorenz Euler step block: a short directed plan
// (origin, word extremes, fixed point, step limit, refused steps) followed by
// random load/step runs under several coefficient settings. Every result is
// compared field by field with planned values or an in-bench fixed-point model.
// ----------------------------------------------------------------------------
module lorenz_euler_step_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import les_pkg::*;

	typedef logic signed [WORD_BITS-1:0] word_t;

	typedef struct packed {
		word_t                x;
		word_t                y;
		word_t                z;
		logic [CNT_BITS-1:0]  cnt;
		logic                 conv;
		logic                 lim;
		logic                 sat;
	} orbit_t;

	typedef struct packed {
		logic                     is_cfg;
		logic [CFG_IDX_BITS-1:0]  idx;
		logic [CFG_DATA_BITS-1:0] cval;
		logic                     kind;
		word_t                    x;
		word_t                    y;
		word_t                    z;
		logic                     known;
		orbit_t                   want;
	} plan_row_t;

	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

	localparam word_t Q_ONE    = 40'sd268435456;
	localparam word_t FIX_XY   = 40'sd1910737588;
	localparam word_t FIX_Z    = 40'sd5100273664;
	localparam word_t START_X  = -40'sd2684354560;
	localparam word_t START_Y  = 40'sd4026531840;
	localparam logic [CFG_DATA_BITS-1:0] COEF_TOP = {COEF_BITS{1'b1}};

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata;   // x_in, y_in, z_in
	logic                     s_tuser;   // kind
	logic                     m_tvalid;
	logic                     m_tready;
	logic [OUT_DATA_BITS-1:0] m_tdata;   // x_out, y_out, z_out, step_count,
	                                     // converged, limit_reached, saturated
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	// integrator model state and register copies
	word_t                 cur_x, cur_y, cur_z;
	logic [CNT_BITS-1:0]   steps_cnt;
	logic                  frozen;
	logic                  clip_hit;
	logic [COEF_BITS-1:0]  k_sigma, k_rho, k_beta;
	logic [SMALL_BITS-1:0] k_h, k_tol;
	logic [CNT_BITS-1:0]   k_max;

	orbit_t    orbit_due[$];
	plan_row_t dir_plan[$];

	int mismatches   = 0;
	int loads_sent   = 0;
	int steps_sent   = 0;
	int results_seen = 0;
	int conv_seen    = 0;
	int lim_seen     = 0;
	int sat_seen     = 0;
	int settings     = 0;
	int burst_left   = 0;
	int tick         = 0;
	int ready_mode   = 0;

	lorenz_euler_step dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------------------------------------------------------- model

	function automatic word_t q_addsub(input word_t a, input word_t b, input logic minus);
		logic signed [WORD_BITS:0] s;
		s = minus ? ((WORD_BITS+1)'(a) - (WORD_BITS+1)'(b))
			: ((WORD_BITS+1)'(a) + (WORD_BITS+1)'(b));
		if (s > $signed({1'b0, WMAX})) begin
			clip_hit = 1'b1;
			return WMAX;
		end
		if (s < $signed({1'b1, WMIN})) begin
			clip_hit = 1'b1;
			return WMIN;
		end
		return word_t'(s);
	endfunction

	// exact product, rounded half away from zero at the binary point
	function automatic word_t q_mul(input word_t a, input word_t b);
		logic signed [2*WORD_BITS:0] p;
		logic [2*WORD_BITS:0]        mag;
		logic [2*WORD_BITS:0]        lim;
		logic                        neg;
		p = (2*WORD_BITS+1)'(a) * (2*WORD_BITS+1)'(b);
		neg = p < 0;
		mag = neg ? -p : p;
		mag = (mag + ((2*WORD_BITS+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		lim = (2*WORD_BITS+1)'(WMAX);
		lim = lim + neg;
		if (mag > lim) begin
			clip_hit = 1'b1;
			mag = lim;
		end
		return neg ? word_t'(-mag) : word_t'(mag);
	endfunction

	function automatic logic q_small(input word_t v, input logic [SMALL_BITS-1:0] tol);
		logic signed [WORD_BITS:0] t;
		t = {{(WORD_BITS + 1 - SMALL_BITS){1'b0}}, tol};
		return (v < t) && (v > -t);
	endfunction

	function automatic orbit_t advance_orbit(input logic kind, input word_t x, input word_t y,
			input word_t z);
		word_t  dx, dy, dz, ix, iy, iz;
		orbit_t o;
		clip_hit = 1'b0;
		if (kind == KIND_LOAD) begin
			cur_x = x;
			cur_y = y;
			cur_z = z;
			steps_cnt = '0;
			frozen = 1'b0;
		end else if (!frozen && steps_cnt < k_max) begin
			dx = q_mul(word_t'(k_sigma), q_addsub(cur_y, cur_x, 1'b1));
			dy = q_addsub(q_mul(cur_x, q_addsub(word_t'(k_rho), cur_z, 1'b1)), cur_y, 1'b1);
			dz = q_addsub(q_mul(cur_x, cur_y), q_mul(word_t'(k_beta), cur_z), 1'b1);
			ix = q_mul(word_t'(k_h), dx);
			iy = q_mul(word_t'(k_h), dy);
			iz = q_mul(word_t'(k_h), dz);
			cur_x = q_addsub(cur_x, ix, 1'b0);
			cur_y = q_addsub(cur_y, iy, 1'b0);
			cur_z = q_addsub(cur_z, iz, 1'b0);
			steps_cnt = steps_cnt + 1'b1;
			if (q_small(ix, k_tol) && q_small(iy, k_tol) && q_small(iz, k_tol)) begin
				frozen = 1'b1;
			end
		end
		o.x = cur_x;
		o.y = cur_y;
		o.z = cur_z;
		o.cnt = steps_cnt;
		o.conv = frozen;
		o.lim = steps_cnt >= k_max;
		o.sat = clip_hit;
		return o;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic word_t rand_word();
		return word_t'({$urandom(), $urandom()});
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] rand_reg();
		return CFG_DATA_BITS'({$urandom(), $urandom()});
	endfunction

	// full range, moderate magnitude, or tiny values close to the origin
	function automatic word_t pick_coord(input int cls);
		if (cls == 0) begin
			return rand_word();
		end
		if (cls < 7) begin
			return rand_word() >>> $urandom_range(4, 12);
		end
		return rand_word() >>> $urandom_range(20, 38);
	endfunction

	function automatic void plan_known(input logic kind, input word_t x, input word_t y,
			input word_t z, input word_t ex, input word_t ey, input word_t ez,
			input logic [CNT_BITS-1:0] ecnt, input logic econv, input logic elim);
		plan_row_t r;
		r = '0;
		r.kind = kind;
		r.x = x;
		r.y = y;
		r.z = z;
		r.known = 1'b1;
		r.want.x = ex;
		r.want.y = ey;
		r.want.z = ez;
		r.want.cnt = ecnt;
		r.want.conv = econv;
		r.want.lim = elim;
		dir_plan.push_back(r);
	endfunction

	function automatic void plan_step();
		plan_row_t r;
		r = '0;
		r.kind = KIND_STEP;
		r.x = rand_word();
		r.y = rand_word();
		r.z = rand_word();
		dir_plan.push_back(r);
	endfunction

	function automatic void plan_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		plan_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.cval = val;
		dir_plan.push_back(r);
	endfunction

	task automatic send_item(input logic kind, input word_t x, input word_t y, input word_t z,
			input logic known, input orbit_t want);
		orbit_t calc;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= IN_DATA_BITS'({z, y, x});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		calc = advance_orbit(kind, x, y, z);
		orbit_due.push_back(known ? want : calc);
		if (kind == KIND_LOAD) loads_sent++;
		else steps_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 60)) @(posedge clk);
			else repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 30);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SIGMA:     k_sigma = val[COEF_BITS-1:0];
			REG_RHO:       k_rho = val[COEF_BITS-1:0];
			REG_BETA:      k_beta = val[COEF_BITS-1:0];
			REG_STEP_H:    k_h = val[SMALL_BITS-1:0];
			REG_TOLERANCE: k_tol = val[SMALL_BITS-1:0];
			REG_MAX_STEPS: k_max = val[CNT_BITS-1:0];
			default: ;
		endcase
	endtask

	// stop sending and wait until every result has been taken
	task automatic drain();
		s_tvalid <= 1'b0;
		while (orbit_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input logic [CFG_DATA_BITS-1:0] sg, input logic [CFG_DATA_BITS-1:0] rh,
			input logic [CFG_DATA_BITS-1:0] bt, input logic [CFG_DATA_BITS-1:0] hh,
			input logic [CFG_DATA_BITS-1:0] tl, input logic [CFG_DATA_BITS-1:0] mx,
			input int n, input int run_max);
		int sent;
		int len;
		int cls;
		drain();
		write_reg(REG_SIGMA, sg);
		write_reg(REG_RHO, rh);
		write_reg(REG_BETA, bt);
		write_reg(REG_STEP_H, hh);
		write_reg(REG_TOLERANCE, tl);
		write_reg(REG_MAX_STEPS, mx);
		write_reg(REG_SPARE_LO, rand_reg());
		write_reg(REG_SPARE_HI, rand_reg());
		settings++;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 99) < 85) begin
				// a load followed by a run of steps
				cls = $urandom_range(0, 9);
				send_item(KIND_LOAD, pick_coord(cls), pick_coord(cls), pick_coord(cls), 1'b0, '0);
				len = $urandom_range(1, run_max);
				repeat (len) begin
					send_item(KIND_STEP, rand_word(), rand_word(), rand_word(), 1'b0, '0);
				end
				sent += len + 1;
			end else begin
				send_item(1'($urandom_range(0, 1)), rand_word(), rand_word(), rand_word(),
					1'b0, '0);
				sent++;
			end
		end
	endtask

	// ---------------------------------------------------------------- checking

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < 40) begin
			$display("%0t ns: %s got %h, expected %h", $time, what, got, want);
		end
		mismatches++;
	endtask

	task automatic check_result();
		orbit_t exp_o;
		orbit_t got_o;
		got_o.x = m_tdata[IO_BITS-1:0];
		got_o.y = m_tdata[2*IO_BITS-1:IO_BITS];
		got_o.z = m_tdata[3*IO_BITS-1:2*IO_BITS];
		got_o.cnt = m_tdata[3*IO_BITS +: CNT_BITS];
		got_o.conv = m_tdata[3*IO_BITS + CNT_BITS];
		got_o.lim = m_tdata[3*IO_BITS + CNT_BITS + 1];
		got_o.sat = m_tdata[3*IO_BITS + CNT_BITS + 2];
		if (orbit_due.size() == 0) begin
			flag_mismatch("result with nothing pending", m_tdata[63:0], '0);
			return;
		end
		exp_o = orbit_due.pop_front();
		results_seen++;
		if (got_o.conv) conv_seen++;
		if (got_o.lim) lim_seen++;
		if (got_o.sat) sat_seen++;
		if (got_o.x !== exp_o.x) flag_mismatch("x_out", got_o.x, exp_o.x);
		if (got_o.y !== exp_o.y) flag_mismatch("y_out", got_o.y, exp_o.y);
		if (got_o.z !== exp_o.z) flag_mismatch("z_out", got_o.z, exp_o.z);
		if (got_o.cnt !== exp_o.cnt) flag_mismatch("step_count", got_o.cnt, exp_o.cnt);
		if (got_o.conv !== exp_o.conv) flag_mismatch("converged", got_o.conv, exp_o.conv);
		if (got_o.lim !== exp_o.lim) flag_mismatch("limit_reached", got_o.lim, exp_o.lim);
		if (got_o.sat !== exp_o.sat) flag_mismatch("saturated", got_o.sat, exp_o.sat);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) check_result();
	end

	// receiver: switches between always ready, coin flip, sparse and periodic
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (tick % 150 == 0) ready_mode = $urandom_range(0, 3);
			case (ready_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (tick % 7) < 4;
			endcase
		end
	end

	// ---------------------------------------------------------------- main sequence

	initial begin
		plan_row_t r;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= KIND_LOAD;
		cfg_we <= 1'b0;
		cfg_index <= REG_SIGMA;
		cfg_data <= '0;
		k_sigma = SIGMA_RST;
		k_rho = RHO_RST;
		k_beta = BETA_RST;
		k_h = STEP_RST;
		k_tol = TOL_RST;
		k_max = MAX_RST;
		cur_x = '0;
		cur_y = '0;
		cur_z = '0;
		steps_cnt = '0;
		frozen = 1'b0;
		settings = 1;

		// the origin is a fixed point: converges on the first step, then holds
		plan_known(KIND_STEP, '0, '0, '0, '0, '0, '0, 20'd1, 1'b1, 1'b0);
		plan_known(KIND_STEP, WMAX, WMIN, Q_ONE, '0, '0, '0, 20'd1, 1'b1, 1'b0);
		plan_reg(REG_SPARE_LO, COEF_TOP);
		plan_known(KIND_LOAD, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, '0, 1'b0, 1'b0);
		plan_step();
		plan_known(KIND_LOAD, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, '0, 1'b0, 1'b0);
		plan_step();
		plan_known(KIND_LOAD, WMAX, WMIN, WMAX, WMAX, WMIN, WMAX, '0, 1'b0, 1'b0);
		plan_step();
		plan_known(KIND_LOAD, WMIN, WMAX, '0, WMIN, WMAX, '0, '0, 1'b0, 1'b0);
		plan_step();
		plan_known(KIND_LOAD, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, Q_ONE, 2 * Q_ONE, 3 * Q_ONE,
			'0, 1'b0, 1'b0);
		plan_step();
		plan_step();
		// near the nonzero equilibrium of the default coefficients
		plan_known(KIND_LOAD, FIX_XY, FIX_XY, FIX_Z, FIX_XY, FIX_XY, FIX_Z, '0, 1'b0, 1'b0);
		plan_step();
		plan_step();
		// step limit of two: third step is refused
		plan_reg(REG_MAX_STEPS, 39'd2);
		plan_known(KIND_LOAD, START_X, START_Y, FIX_Z, START_X, START_Y, FIX_Z,
			'0, 1'b0, 1'b0);
		plan_step();
		plan_step();
		plan_step();
		plan_known(KIND_LOAD, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
		// no steps allowed at all
		plan_reg(REG_MAX_STEPS, '0);
		plan_reg(REG_SPARE_HI, '0);
		plan_known(KIND_STEP, Q_ONE, Q_ONE, Q_ONE, '0, '0, '0, '0, 1'b0, 1'b1);
		plan_known(KIND_LOAD, Q_ONE, -Q_ONE, '0, Q_ONE, -Q_ONE, '0, '0, 1'b0, 1'b1);
		plan_known(KIND_STEP, '0, '0, '0, Q_ONE, -Q_ONE, '0, '0, 1'b0, 1'b1);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_plan[i]) begin
			r = dir_plan[i];
			if (r.is_cfg) begin
				drain();
				write_reg(r.idx, r.cval);
			end else begin
				send_item(r.kind, r.x, r.y, r.z, r.known, r.want);
			end
		end

		run_phase(SIGMA_RST, RHO_RST, BETA_RST, STEP_RST, TOL_RST, MAX_RST, 300, 20);
		run_phase(SIGMA_RST, 39'd7516192768, BETA_RST, 39'd2684354, 39'd268,
			CFG_DATA_BITS'($urandom_range(1, 30)), 250, 40);
		run_phase(COEF_TOP, COEF_TOP, COEF_TOP, 39'h1fff_ffff, 39'h1fff_ffff, 39'hf_ffff,
			150, 20);
		run_phase('0, '0, '0, '0, '0, '0, 60, 10);
		run_phase('0, '0, '0, 39'd268435456, '0, 39'hf_ffff, 100, 20);
		repeat (3) begin
			run_phase(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg(),
				150, 30);
		end

		drain();
		repeat (60) @(posedge clk);

		$display("sent %0d items (%0d loads, %0d steps) under %0d register settings",
			loads_sent + steps_sent, loads_sent, steps_sent, settings);
		$display("checked %0d results: %0d converged, %0d at step limit, %0d saturated",
			results_seen, conv_seen, lim_seen, sat_seen);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
